// File: design/mm3_pkg.sv
// Shared constants and types for the MurmurHash3 x86_32 hash engine.
// No dependencies; used by mm3_mul, murmur3_32_hash_engine and its testbench.
package mm3_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CNT_W  = 3;
    // s_axis tdata: data_word (32) + byte_count (3), padded to whole bytes
    localparam int unsigned S_TDATA_W = 40;

    localparam logic [WORD_W-1:0] C1    = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] C2    = 32'h1b873593;
    localparam logic [WORD_W-1:0] MIX_N = 32'he6546b64;
    localparam logic [WORD_W-1:0] F1    = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] F2    = 32'hc2b2ae35;

    localparam logic [CNT_W-1:0] CNT_FULL = 3'd4;

    // request to the shared multiplier
    typedef struct packed {
        logic              en;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

endpackage

// File: design/mm3_mul.sv
// Shared 32x32 multiplier (low 32 bits of the product), registered output.
// Depends on mm3_pkg.
module mm3_mul (
    input  logic                         clk,
    input  mm3_pkg::mul_req_t            req,
    output logic [mm3_pkg::WORD_W-1:0]   prod
);

    logic [mm3_pkg::WORD_W-1:0] prod_reg;
    logic [mm3_pkg::WORD_W-1:0] prod_next;

    // product is only modulo 2^32, so the low half is all that is kept
    assign prod_next = req.en ? (req.a * req.b) : prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// File: design/murmur3_32_hash_engine.sv
// Top level of the streaming MurmurHash3 x86_32 hash engine.
// Depends on mm3_pkg and mm3_mul.
//
// Hashes a key streamed as little-endian words (first byte in bits 7:0) with
// a byte count of 0..4 per request; counts 5..7 count as 4. A full word is
// mixed as a block; a word of one to three bytes is the tail and always ends
// the key; tlast ends the key too, and a zero-byte request with tlast ends it
// as it stands. The first request of a key loads the hash from the seed
// register (write it between keys; a write lands at the next key). At the end
// of a key the byte length (mod 2^32) is folded in, the final avalanche runs,
// and one hash is presented on m_axis. All multiplies go through one
// registered 32x32 multiplier under a small sequencer, and s_axis_tready is
// high only when the sequencer is idle. A full word without end of key is
// accepted, then takes two multiplies and a hash update; ending a key adds
// two more multiplies and the output load. An empty last request goes from
// accept straight to those; an empty request without tlast leaves the
// sequencer idle. The output stage holds a hash until taken; the sequencer
// waits in its output step only if the previous hash is still unclaimed.
module murmur3_32_hash_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    // key input: tdata[31:0] data_word, tdata[34:32] byte_count, rest zero
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mm3_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    // hash output: tdata[31:0] hash_value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mm3_pkg::WORD_W-1:0]        m_axis_tdata,
    // seed register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mm3_pkg::WORD_W-1:0]        cfg_data
);

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX1 = 3'd1; // k * C1
    localparam logic [2:0] ST_MIX2 = 3'd2; // rotl(k,15) * C2
    localparam logic [2:0] ST_UPD  = 3'd3; // fold k into hash
    localparam logic [2:0] ST_FIN1 = 3'd4; // fmix step * F1
    localparam logic [2:0] ST_FIN2 = 3'd5; // fmix step * F2
    localparam logic [2:0] ST_FIN3 = 3'd6; // final shift-xor, load output

    logic [2:0]                   state_reg, state_next;
    logic                         key_open_reg, key_open_next;
    logic [mm3_pkg::WORD_W-1:0]   seed_reg, seed_next;
    logic                         out_valid_reg, out_valid_next;
    logic [mm3_pkg::WORD_W-1:0]   out_data_reg, out_data_next;
    logic [mm3_pkg::WORD_W-1:0]   hash_reg, hash_next;
    logic [mm3_pkg::WORD_W-1:0]   len_reg, len_next;
    logic [mm3_pkg::WORD_W-1:0]   word_reg, word_next;
    logic                         tail_reg, tail_next;
    logic                         done_reg, done_next;

    logic                         in_req;
    logic [mm3_pkg::WORD_W-1:0]   in_word;
    logic [mm3_pkg::CNT_W-1:0]    in_cnt;
    logic [mm3_pkg::CNT_W-1:0]    cnt_sat;
    logic [mm3_pkg::WORD_W-1:0]   byte_mask;
    logic [mm3_pkg::WORD_W-1:0]   base_hash;
    logic [mm3_pkg::WORD_W-1:0]   base_len;
    logic                         in_tail;
    logic                         in_done;

    mm3_pkg::mul_req_t            mul_req;
    logic [mm3_pkg::WORD_W-1:0]   prod;
    logic [mm3_pkg::WORD_W-1:0]   k_rot;
    logic [mm3_pkg::WORD_W-1:0]   h_mix;
    logic [mm3_pkg::WORD_W-1:0]   h_rot;
    logic [mm3_pkg::WORD_W-1:0]   fin_a;
    logic [mm3_pkg::WORD_W-1:0]   fin_b;
    logic                         out_free;

    mm3_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign in_word       = s_axis_tdata[mm3_pkg::WORD_W-1:0];
    assign in_cnt        = s_axis_tdata[mm3_pkg::WORD_W+mm3_pkg::CNT_W-1:mm3_pkg::WORD_W];
    assign cnt_sat       = (in_cnt > mm3_pkg::CNT_FULL) ? mm3_pkg::CNT_FULL : in_cnt;
    assign in_tail       = (cnt_sat != '0) && (cnt_sat != mm3_pkg::CNT_FULL);
    assign in_done       = in_tail || s_axis_tlast;

    // a new key starts from the seed with zero length
    assign base_hash = key_open_reg ? hash_reg : seed_reg;
    assign base_len  = key_open_reg ? len_reg : '0;

    always_comb
    begin
        unique case (cnt_sat)
            3'd0:    byte_mask = 32'h00000000;
            3'd1:    byte_mask = 32'h000000ff;
            3'd2:    byte_mask = 32'h0000ffff;
            3'd3:    byte_mask = 32'h00ffffff;
            default: byte_mask = 32'hffffffff;
        endcase
    end

    // rotations are wiring
    assign k_rot = {prod[16:0], prod[31:17]};          // rotl 15
    assign h_mix = hash_reg ^ prod;
    assign h_rot = {h_mix[18:0], h_mix[31:19]};        // rotl 13
    assign fin_a = (hash_reg ^ len_reg) ^ ((hash_reg ^ len_reg) >> 16);
    assign fin_b = prod ^ (prod >> 13);

    assign out_free = !out_valid_reg || m_axis_tready;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // multiplier operand select
    always_comb
    begin
        mul_req.en = 1'b0;
        mul_req.a  = word_reg;
        mul_req.b  = mm3_pkg::C1;
        unique case (state_reg)
            ST_MIX1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = word_reg;
                mul_req.b  = mm3_pkg::C1;
            end
            ST_MIX2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = k_rot;
                mul_req.b  = mm3_pkg::C2;
            end
            ST_FIN1:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = fin_a;
                mul_req.b  = mm3_pkg::F1;
            end
            ST_FIN2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = fin_b;
                mul_req.b  = mm3_pkg::F2;
            end
            default:
            begin
                mul_req.en = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        key_open_next  = key_open_reg;
        seed_next      = seed_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        hash_next      = hash_reg;
        len_next       = len_reg;
        word_next      = word_reg;
        tail_next      = tail_reg;
        done_next      = done_reg;

        if (cfg_valid && cfg_ready)
        begin
            seed_next = cfg_data;
        end
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_req)
                begin
                    hash_next     = base_hash;
                    len_next      = base_len + {{(mm3_pkg::WORD_W-mm3_pkg::CNT_W){1'b0}}, cnt_sat};
                    word_next     = in_word & byte_mask;
                    tail_next     = in_tail;
                    done_next     = in_done;
                    key_open_next = !in_done;
                    if (cnt_sat != '0)
                    begin
                        state_next = ST_MIX1;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = ST_FIN1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MIX1:
            begin
                state_next = ST_MIX2;
            end
            ST_MIX2:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (tail_reg)
                begin
                    hash_next = h_mix;
                end
                else
                begin
                    // h * 5 + n as shift-add
                    hash_next = (h_rot << 2) + h_rot + mm3_pkg::MIX_N;
                end
                state_next = done_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1:
            begin
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                state_next = ST_FIN3;
            end
            ST_FIN3:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = prod ^ (prod >> 16);
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            key_open_reg  <= 1'b0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_open_reg  <= key_open_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        hash_reg     <= hash_next;
        len_reg      <= len_next;
        word_reg     <= word_next;
        tail_reg     <= tail_next;
        done_reg     <= done_next;
    end

endmodule

// File: tb/sv/murmur3_32_hash_engine_tb.sv
// Self-checking testbench for murmur3_32_hash_engine (streaming MurmurHash3 x86_32).
// Depends on mm3_pkg and the engine RTL. The hash is predicted in a scoreboard class,
// and random keys, seeds and bus stalls are driven against it.
module murmur3_32_hash_engine_tb;

    localparam int unsigned RANDOM_ITEMS  = 1400;
    localparam int unsigned SEED_PHASES   = 5;
    localparam int unsigned SETTLE_CYCLES = 12;   // covers the longest no-result request
    localparam int unsigned QUIET_LIMIT   = 3000; // cycles with no handshake at all
    localparam int unsigned HOLD_CYCLES   = 400;  // long output back-pressure stretch
    localparam int unsigned HOLD_AFTER    = 60;   // hashes seen before that stretch

    // how a random key is closed
    typedef enum logic [1:0] {
        END_TAIL,
        END_FULL_LAST,
        END_EMPTY_LAST,
        END_NONE
    } key_end_t;

    // Predicts the engine hash by hash and keeps the expected ones in order.
    class hash_scoreboard;
        logic [mm3_pkg::WORD_W-1:0] seed;
        logic [mm3_pkg::WORD_W-1:0] running_hash;
        logic [mm3_pkg::WORD_W-1:0] key_length;
        bit                         key_open;
        logic [mm3_pkg::WORD_W-1:0] expected_hashes[$];
        int unsigned                hashes_checked;
        int unsigned                fail_count;

        function new();
            seed           = '0;
            running_hash   = '0;
            key_length     = '0;
            key_open       = 1'b0;
            hashes_checked = 0;
            fail_count     = 0;
        endfunction

        function logic [mm3_pkg::WORD_W-1:0] rotl(input logic [mm3_pkg::WORD_W-1:0] v,
                                                  input int unsigned s);
            return (v << s) | (v >> (mm3_pkg::WORD_W - s));
        endfunction

        function logic [mm3_pkg::WORD_W-1:0] scramble(input logic [mm3_pkg::WORD_W-1:0] k);
            logic [mm3_pkg::WORD_W-1:0] t;
            t = k * mm3_pkg::C1;
            t = rotl(t, 15);
            t = t * mm3_pkg::C2;
            return t;
        endfunction

        function logic [mm3_pkg::WORD_W-1:0] avalanche(input logic [mm3_pkg::WORD_W-1:0] h,
                                                       input logic [mm3_pkg::WORD_W-1:0] len);
            logic [mm3_pkg::WORD_W-1:0] t;
            t = h ^ len;
            t = t ^ (t >> 16);
            t = t * mm3_pkg::F1;
            t = t ^ (t >> 13);
            t = t * mm3_pkg::F2;
            t = t ^ (t >> 16);
            return t;
        endfunction

        function void set_seed(input logic [mm3_pkg::WORD_W-1:0] v);
            seed = v;
        endfunction

        // accepted key request; pushes a hash when it ends the key
        function void note_request(input logic [mm3_pkg::WORD_W-1:0] word,
                                   input logic [mm3_pkg::CNT_W-1:0]  cnt,
                                   input bit                         last);
            logic [mm3_pkg::CNT_W-1:0]  n;
            logic [mm3_pkg::WORD_W-1:0] mask;
            bit                         done;
            if (!key_open)
            begin
                running_hash = seed;
                key_length   = '0;
                key_open     = 1'b1;
            end
            n = (cnt > mm3_pkg::CNT_FULL) ? mm3_pkg::CNT_FULL : cnt;
            if (n == mm3_pkg::CNT_FULL)
            begin
                running_hash = rotl(running_hash ^ scramble(word), 13) * 32'd5
                               + mm3_pkg::MIX_N;
                key_length   = key_length + 32'd4;
                done         = last;
            end
            else if (n != 0)
            begin
                mask         = (32'd1 << (8 * n)) - 32'd1;
                running_hash = running_hash ^ scramble(word & mask);
                key_length   = key_length + 32'(n);
                done         = 1'b1;
            end
            else
            begin
                done = last;
            end
            if (done)
            begin
                expected_hashes.push_back(avalanche(running_hash, key_length));
                key_open = 1'b0;
            end
        endfunction

        function void check_hash(input logic [mm3_pkg::WORD_W-1:0] actual);
            logic [mm3_pkg::WORD_W-1:0] want;
            if (expected_hashes.size() == 0)
            begin
                $error("hash_value: unexpected result %h", actual);
                fail_count++;
                return;
            end
            want = expected_hashes.pop_front();
            hashes_checked++;
            if (actual !== want)
            begin
                $error("hash_value mismatch: expected %h, actual %h", want, actual);
                fail_count++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // [31:0] data_word, [34:32] byte_count, rest zero
    logic [mm3_pkg::S_TDATA_W-1:0]  s_axis_tdata;
    logic                           s_axis_tlast;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [mm3_pkg::WORD_W-1:0]     m_axis_tdata;   // [31:0] hash_value
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [mm3_pkg::WORD_W-1:0]     cfg_data;

    hash_scoreboard sb;
    int unsigned    requests_sent;
    int unsigned    quiet_cycles;
    bit             hold_done;

    murmur3_32_hash_engine DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // One key request; returns at the edge where it is accepted.
    task automatic send_request(input logic [mm3_pkg::WORD_W-1:0] word,
                                input logic [mm3_pkg::CNT_W-1:0]  cnt,
                                input bit                         last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(mm3_pkg::S_TDATA_W - mm3_pkg::WORD_W - mm3_pkg::CNT_W){1'b0}},
                          cnt, word};
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_request(word, cnt, last);
        requests_sent++;
    endtask

    // Quiesce the input, drain pending hashes, then let an in-flight
    // no-result request finish before touching the seed.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_hashes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [mm3_pkg::WORD_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_seed(v);
    endtask

    function automatic logic [mm3_pkg::WORD_W-1:0] random_word();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Well-formed key with random content; a few keys are left open so the
    // next one continues them, and stray empty requests show up mid key.
    task automatic send_random_key();
        int unsigned n_full;
        int unsigned r;
        key_end_t    how;
        r = $urandom_range(0, 99);
        if (r < 70)
            n_full = $urandom_range(0, 3);
        else if (r < 95)
            n_full = $urandom_range(4, 10);
        else
            n_full = $urandom_range(11, 30);
        for (int i = 0; i < n_full; i++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                send_request(random_word(), 3'd0, 1'b0);
                requests_sent--;  // ignored request, not counted
            end
            if ($urandom_range(0, 9) == 0)
                send_request(random_word(), 3'($urandom_range(5, 7)), 1'b0);
            else
                send_request(random_word(), mm3_pkg::CNT_FULL, 1'b0);
        end
        r = $urandom_range(0, 99);
        if (r < 45)
            how = END_TAIL;
        else if (r < 75)
            how = END_FULL_LAST;
        else if (r < 95)
            how = END_EMPTY_LAST;
        else
            how = END_NONE;
        case (how)
            END_TAIL:       send_request(random_word(), 3'($urandom_range(1, 3)),
                                         1'($urandom_range(0, 1)));
            END_FULL_LAST:  send_request(random_word(), 3'($urandom_range(4, 7)), 1'b1);
            END_EMPTY_LAST: send_request(random_word(), 3'd0, 1'b1);
            default:        ;
        endcase
    endtask

    // Result side: random ready with short and long stalls, plus one long
    // hold-off once traffic is flowing so the engine backs up into s_axis.
    initial
    begin
        int unsigned on_cycles;
        int unsigned off_cycles;
        int unsigned r;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && sb.hashes_checked >= HOLD_AFTER)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 50)
                off_cycles = 0;
            else if (r < 92)
                off_cycles = $urandom_range(1, 3);
            else
                off_cycles = $urandom_range(10, 50);
            on_cycles = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                    : $urandom_range(1, 12);
            if (off_cycles != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (off_cycles) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat (on_cycles) @(posedge clk);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_hash(m_axis_tdata);
    end

    // watchdog: any handshake on any channel restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        logic [mm3_pkg::WORD_W-1:0] phase_seed [SEED_PHASES];
        int unsigned                directed_count;
        sb            = new();
        requests_sent = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed keys, seed at its reset value
        send_request(32'h0000_0000, 3'd0, 1'b1);                // empty key
        send_request(32'hffff_ffff, mm3_pkg::CNT_FULL, 1'b1);   // one full word
        send_request(32'h0000_0000, mm3_pkg::CNT_FULL, 1'b0);
        send_request(32'h1234_5678, mm3_pkg::CNT_FULL, 1'b0);
        send_request(32'hff9a_bcde, 3'd3, 1'b0);            // tail ends key without tlast
        send_request(32'hffff_ffff, 3'd1, 1'b1);            // one byte, junk above it
        send_request(32'hffff_ffff, 3'd2, 1'b1);
        send_request(32'ha5a5_5a5a, 3'd5, 1'b0);            // counts over four saturate
        send_request(32'h5a5a_a5a5, 3'd7, 1'b1);
        send_request(32'h0f0f_f0f0, 3'd6, 1'b0);
        send_request(32'hdead_beef, 3'd0, 1'b1);            // empty request closes key
        send_request(32'hffff_ffff, 3'd0, 1'b0);            // empty request opens key
        send_request(32'hcafe_f00d, mm3_pkg::CNT_FULL, 1'b0);
        send_request(32'h0000_0000, 3'd0, 1'b0);            // ignored mid key
        send_request(32'h8765_4321, 3'd2, 1'b1);
        // seed change with a key open: only the next key sees it
        send_request(32'hdead_beef, mm3_pkg::CNT_FULL, 1'b0);
        wait_idle();
        write_seed(32'hffff_ffff);
        send_request(32'h0bad_cafe, mm3_pkg::CNT_FULL, 1'b1);
        send_request(32'h0000_00ff, 3'd1, 1'b1);
        wait_idle();
        directed_count = requests_sent;

        phase_seed[0] = 32'hffff_ffff;
        phase_seed[1] = 32'h0000_0000;
        phase_seed[2] = $urandom;
        phase_seed[3] = 32'h8000_0001;
        phase_seed[4] = $urandom;
        for (int p = 0; p < SEED_PHASES; p++)
        begin
            write_seed(phase_seed[p]);
            while (requests_sent < directed_count + (p + 1) * (RANDOM_ITEMS / SEED_PHASES))
                send_random_key();
            wait_idle();
        end

        if (sb.fail_count == 0 && sb.expected_hashes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/mm3_pkg.sv
design/mm3_mul.sv
design/murmur3_32_hash_engine.sv
tb/sv/murmur3_32_hash_engine_tb.sv
